// File: design/fapr_pkg.sv
// Shared types and constants for the fit-and-pad resize source address block.
// No dependencies; imported by every design file.
package fapr_pkg;

	localparam int XY_W    = 12;
	localparam int DIM_W   = 13;
	localparam int ADDR_W  = 24;
	localparam int IDX_W   = 8;
	// largest picture size; register values above it are used as this
	localparam int MAX_DIM = 4096;

	// configuration register indexes
	localparam logic [IDX_W-1:0] CFG_SRC_WIDTH  = 8'd0;
	localparam logic [IDX_W-1:0] CFG_SRC_HEIGHT = 8'd1;
	localparam logic [IDX_W-1:0] CFG_DST_WIDTH  = 8'd2;
	localparam logic [IDX_W-1:0] CFG_DST_HEIGHT = 8'd3;

	typedef struct packed {
		logic [XY_W-1:0] out_x;
		logic [XY_W-1:0] out_y;
	} in_item_t;

	typedef struct packed {
		logic [XY_W-1:0]   src_x;
		logic [XY_W-1:0]   src_y;
		logic [ADDR_W-1:0] src_addr;
		logic              outside;
	} out_item_t;

	// effective (clamped) picture sizes
	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] dw;
		logic [DIM_W-1:0] dh;
	} dims_t;

	// per-configuration fit parameters
	typedef struct packed {
		logic             mode_h;  // height factor, columns padded
		logic [DIM_W-1:0] offset;  // left pad or top pad
		logic [DIM_W-1:0] sdim;    // scaled width (height mode) or height
	} fit_t;

endpackage

// File: design/fit_and_pad_resize_source_address.sv
// Top level: fit-and-pad nearest-neighbor resize source address pipeline.
// Depends on fapr_pkg and fapr_setup.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------
//  input    | start / busy        | in_item (out_x, out_y)
//  result   | done (strobe)       | result (src_x, src_y, src_addr, outside)
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle while busy is low. Path from accept to the done strobe: a
// bounds register, a registered multiply, a 13-stage quotient pipeline, clamp,
// address multiply and add. After reset and after each config write, busy stays
// high while the fit unit loads its products and runs its 25-step serial divide.
// The result side has no backpressure; the pipeline always advances.
module fit_and_pad_resize_source_address (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  fapr_pkg::in_item_t            in_item,
	output logic                          done,
	output fapr_pkg::out_item_t           result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fapr_pkg::IDX_W-1:0]    cfg_index,
	input  logic [fapr_pkg::DIM_W-1:0]    cfg_data
);
	import fapr_pkg::*;

	localparam int QB    = DIM_W;        // quotient bits
	localparam int REM_W = XY_W + DIM_W; // dividend width

	logic [DIM_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	dims_t            dims;
	fit_t             fit;
	logic             cfg_we;
	logic             accept;
	logic [DIM_W-1:0] num, den;

	function automatic logic [DIM_W-1:0] eff(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= DIM_W'(1);
			src_h_q <= DIM_W'(1);
			dst_w_q <= DIM_W'(1);
			dst_h_q <= DIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SRC_WIDTH:  src_w_q <= cfg_data;
				CFG_SRC_HEIGHT: src_h_q <= cfg_data;
				CFG_DST_WIDTH:  dst_w_q <= cfg_data;
				CFG_DST_HEIGHT: dst_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dims.w  = eff(src_w_q);
	assign dims.h  = eff(src_h_q);
	assign dims.dw = eff(dst_w_q);
	assign dims.dh = eff(dst_h_q);

	fapr_setup u_setup (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_we),
		.dims    (dims),
		.fit     (fit),
		.busy    (busy)
	);

	assign accept = start && !busy;
	assign num    = fit.mode_h ? dims.dh : dims.dw;
	assign den    = fit.mode_h ? dims.h  : dims.w;

	// stage 1: bounds and scaled coordinates
	logic             v_s1, out_s1;
	logic [XY_W-1:0]  ix_s1, iy_s1;
	logic [DIM_W-1:0] xe, ye, ixc, iyc;
	logic             outside_c;

	always_comb begin
		xe        = {1'b0, in_item.out_x};
		ye        = {1'b0, in_item.out_y};
		outside_c = (xe >= dims.dw) || (ye >= dims.dh);
		ixc       = xe;
		iyc       = ye;
		if (fit.mode_h) begin
			ixc = (xe < fit.offset) ? '0 : xe - fit.offset;
			if (fit.sdim == '0) begin
				ixc = '0;
			end else if (ixc > fit.sdim - 1'b1) begin
				ixc = fit.sdim - 1'b1;
			end
		end else begin
			iyc = (ye < fit.offset) ? '0 : ye - fit.offset;
		end
		if (outside_c) begin
			ixc = '0;
			iyc = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		out_s1 <= outside_c;
		ix_s1  <= ixc[XY_W-1:0];
		iy_s1  <= iyc[XY_W-1:0];
	end

	// stage 2 and quotient stages: index 0 holds the products
	logic             v_s2 [QB+1];
	logic             out_s2 [QB+1];
	logic [REM_W-1:0] rx_s2 [QB+1];
	logic [REM_W-1:0] ry_s2 [QB+1];
	logic [QB-1:0]    qx_s2 [QB+1];
	logic [QB-1:0]    qy_s2 [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2[0] <= 1'b0;
		end else begin
			v_s2[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_s2[0] <= out_s1;
		rx_s2[0]  <= REM_W'(ix_s1) * REM_W'(den);
		ry_s2[0]  <= REM_W'(iy_s1) * REM_W'(den);
		qx_s2[0]  <= '0;
		qy_s2[0]  <= '0;
	end

	for (genvar st = 0; st < QB; st++) begin : g_div
		localparam int B = QB - 1 - st;
		logic [REM_W:0] trial;
		assign trial = {{(REM_W+1-DIM_W){1'b0}}, num} << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[st+1] <= 1'b0;
			end else begin
				v_s2[st+1] <= v_s2[st];
			end
		end

		always_ff @(posedge clk) begin
			out_s2[st+1] <= out_s2[st];
			if ({1'b0, rx_s2[st]} >= trial) begin
				rx_s2[st+1]    <= rx_s2[st] - trial[REM_W-1:0];
				qx_s2[st+1]    <= qx_s2[st] | (QB'(1) << B);
			end else begin
				rx_s2[st+1]    <= rx_s2[st];
				qx_s2[st+1]    <= qx_s2[st];
			end
			if ({1'b0, ry_s2[st]} >= trial) begin
				ry_s2[st+1]    <= ry_s2[st] - trial[REM_W-1:0];
				qy_s2[st+1]    <= qy_s2[st] | (QB'(1) << B);
			end else begin
				ry_s2[st+1]    <= ry_s2[st];
				qy_s2[st+1]    <= qy_s2[st];
			end
		end
	end

	// stage 3: clamp to the source picture
	logic            v_s3, out_s3;
	logic [XY_W-1:0] sx_s3, sy_s3;
	logic [DIM_W-1:0] wm1, hm1;

	assign wm1 = dims.w - 1'b1;
	assign hm1 = dims.h - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2[QB];
		end
	end

	always_ff @(posedge clk) begin
		out_s3 <= out_s2[QB];
		sx_s3  <= (qx_s2[QB] > wm1) ? wm1[XY_W-1:0] : qx_s2[QB][XY_W-1:0];
		sy_s3  <= (qy_s2[QB] > hm1) ? hm1[XY_W-1:0] : qy_s2[QB][XY_W-1:0];
	end

	// stage 4: row offset
	logic             v_s4, out_s4;
	logic [XY_W-1:0]  sx_s4, sy_s4;
	logic [REM_W-1:0] row_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		out_s4 <= out_s3;
		sx_s4  <= sx_s3;
		sy_s4  <= sy_s3;
		row_s4 <= REM_W'(sy_s3) * REM_W'(dims.w);
	end

	// output register
	logic        done_q;
	out_item_t   result_q;
	logic [REM_W-1:0] addr_full;

	assign addr_full = row_s4 + REM_W'(sx_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (out_s4) begin
			result_q.src_x    <= '0;
			result_q.src_y    <= '0;
			result_q.src_addr <= '0;
			result_q.outside  <= 1'b1;
		end else begin
			result_q.src_x    <= sx_s4;
			result_q.src_y    <= sy_s4;
			result_q.src_addr <= addr_full[ADDR_W-1:0];
			result_q.outside  <= 1'b0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: design/fapr_setup.sv
// Fit parameter unit: picks the scale axis and computes the scaled size and
// pad offset with a bit-serial divider. Depends on fapr_pkg.
module fapr_setup (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           restart,
	input  fapr_pkg::dims_t dims,
	output fapr_pkg::fit_t fit,
	output logic           busy
);
	import fapr_pkg::*;

	localparam int PROD_W = 2 * DIM_W;
	localparam int DVD_W  = 25;
	localparam int CNT_W  = $clog2(DVD_W);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_LOAD = 5'b00010,
		S_MUL  = 5'b00100,
		S_DIV  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t              state_q;
	logic [PROD_W-1:0]   pa_q, pb_q;
	logic [DVD_W-1:0]    dvd_q;
	logic [DIM_W:0]      rem_q;
	logic [DIM_W-1:0]    dsr_q;
	logic [CNT_W-1:0]    cnt_q;
	fit_t                fit_q;
	logic [DIM_W:0]      rem_sh;
	logic                qbit;
	logic                mode_h;
	logic [DIM_W-1:0]    sd;

	assign mode_h = pa_q > pb_q;
	assign rem_sh = {rem_q[DIM_W-1:0], dvd_q[DVD_W-1]};
	assign qbit   = rem_sh >= {1'b0, dsr_q};
	assign sd     = dvd_q[DIM_W-1:0];

	// S_LOAD lets the product registers capture the new sizes before S_MUL uses them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			fit_q   <= '0;
		end else if (restart) begin
			state_q <= S_LOAD;
		end else begin
			case (state_q)
				S_LOAD: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(DVD_W - 1)) begin
						state_q <= S_FIN;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_FIN: begin
					state_q      <= S_IDLE;
					fit_q.mode_h <= fit_q.mode_h;
					fit_q.sdim   <= sd;
					if (fit_q.mode_h) begin
						fit_q.offset <= (dims.dw - sd) >> 1;
					end else begin
						fit_q.offset <= dims.dh - sd;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (state_q == S_MUL) begin
				fit_q.mode_h <= mode_h;
				cnt_q        <= '0;
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		pa_q <= PROD_W'(dims.h) * PROD_W'(dims.dw);
		pb_q <= PROD_W'(dims.dh) * PROD_W'(dims.w);
		if (state_q == S_MUL) begin
			rem_q <= '0;
			if (mode_h) begin
				dvd_q <= pb_q[DVD_W-1:0];
				dsr_q <= dims.h;
			end else begin
				dvd_q <= pa_q[DVD_W-1:0];
				dsr_q <= dims.w;
			end
		end else if (state_q == S_DIV) begin
			rem_q <= qbit ? rem_sh - {1'b0, dsr_q} : rem_sh;
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
		end
	end

	assign fit  = fit_q;
	assign busy = state_q != S_IDLE;

endmodule

// File: design/fapr_checker.sv
// Port-level checks for fit_and_pad_resize_source_address, bound to the top.
// Depends on fapr_pkg.
module fapr_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input fapr_pkg::out_item_t        result,
	input logic                       cfg_valid,
	input logic                       cfg_ready
);
	import fapr_pkg::*;

	localparam int LATENCY = 18;

	// every strobe traces back to an accepted item
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("done without matching item");

	// every accepted item yields a strobe
	a_item_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("item lost");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.outside) |->
		(result.src_x == '0 && result.src_y == '0 && result.src_addr == '0))
		else $error("outside item with nonzero fields");

	// a config write reruns the fit unit
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> busy)
		else $error("not busy after config write");

endmodule

bind fit_and_pad_resize_source_address fapr_checker u_fapr_checker (.*);

// File: tb/tb.sv
// Testbench for fit_and_pad_resize_source_address: directed and random items
// checked against a behavioral predictor of the source pixel mapping.
// Depends on fapr_pkg and the design files.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fapr_pkg::*;

	localparam int SETTLE_CYCLES = 30;
	localparam int STALL_LIMIT   = 5000;

	typedef enum {ST_ITEM, ST_CFG, ST_DRAIN} step_kind_e;
	typedef struct {
		step_kind_e       kind;
		in_item_t         item;
		logic [IDX_W-1:0] idx;
		logic [DIM_W-1:0] data;
		int               gap;
	} step_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	in_item_t         in_item;
	logic             done;
	out_item_t        result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0] cfg_data;

	step_t     pending_q[$];
	out_item_t src_pixel_q[$];
	logic [DIM_W-1:0] size_regs [4];
	logic item_acc, cfg_acc;
	int   settle_cnt;
	int   stall_cnt;
	int   errors;

	fit_and_pad_resize_source_address DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic longint unsigned clamp_dim(logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (v > 4096) return 4096;
		return v;
	endfunction

	function automatic out_item_t src_pixel_for(in_item_t it);
		longint unsigned w, h, dw, dh, x, y, num, den, ix, iy, sx, sy, sw, sh, lpad, tpad;
		out_item_t r;
		w  = clamp_dim(size_regs[CFG_SRC_WIDTH]);
		h  = clamp_dim(size_regs[CFG_SRC_HEIGHT]);
		dw = clamp_dim(size_regs[CFG_DST_WIDTH]);
		dh = clamp_dim(size_regs[CFG_DST_HEIGHT]);
		x = it.out_x;
		y = it.out_y;
		r = '0;
		if (x >= dw || y >= dh) begin
			r.outside = 1'b1;
			return r;
		end
		if (h * dw > dh * w) begin
			// fit by height, columns padded left/right
			sw = (w * dh) / h;
			lpad = (dw - sw) / 2;
			num = dh;
			den = h;
			ix = (x < lpad) ? 0 : x - lpad;
			if (sw == 0) ix = 0;
			else if (ix > sw - 1) ix = sw - 1;
			iy = y;
		end else begin
			// fit by width, rows padded at top
			sh = (h * dw) / w;
			tpad = dh - sh;
			num = dw;
			den = w;
			ix = x;
			iy = (y < tpad) ? 0 : y - tpad;
		end
		sx = (ix * den) / num;
		sy = (iy * den) / num;
		if (sx > w - 1) sx = w - 1;
		if (sy > h - 1) sy = h - 1;
		r.src_x = sx[XY_W-1:0];
		r.src_y = sy[XY_W-1:0];
		r.src_addr = (sy * w + sx) & 64'hFFFFFF;
		return r;
	endfunction

	task automatic add_item(int x, int y, int gap);
		step_t s;
		s = '{kind: ST_ITEM, item: '0, idx: '0, data: '0, gap: gap};
		s.item.out_x = x[XY_W-1:0];
		s.item.out_y = y[XY_W-1:0];
		pending_q.push_back(s);
	endtask

	task automatic add_cfg(logic [IDX_W-1:0] idx, int data);
		pending_q.push_back('{kind: ST_CFG, item: '0, idx: idx, data: data[DIM_W-1:0],
			gap: $urandom_range(0, 13)});
	endtask

	task automatic add_drain();
		pending_q.push_back('{kind: ST_DRAIN, item: '0, idx: '0, data: '0, gap: 0});
	endtask

	task automatic add_sizes(int sw, int sh, int dw, int dh);
		add_drain();
		add_cfg(CFG_SRC_WIDTH, sw);
		add_cfg(CFG_SRC_HEIGHT, sh);
		add_cfg(CFG_DST_WIDTH, dw);
		add_cfg(CFG_DST_HEIGHT, dh);
	endtask

	function automatic int rand_dim();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(4097, 8191);
			2, 3: return $urandom_range(1, 4096);
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	function automatic int rand_coord(longint unsigned lim);
		if ($urandom_range(0, 7) == 0) return $urandom_range(0, 4095);
		return $urandom_range(0, (lim + 2 > 4095) ? 4095 : lim + 2);
	endfunction

	// driver: one step at a time, inputs change on the falling edge
	always @(negedge clk) begin
		logic nstart, nvalid;
		if (arst_n) begin
			nstart = start && !item_acc;
			nvalid = cfg_valid && !cfg_acc;
			if (!nstart && !nvalid && pending_q.size() > 0) begin
				if (pending_q[0].kind == ST_DRAIN) begin
					if (src_pixel_q.size() != 0) settle_cnt = 0;
					else if (settle_cnt >= SETTLE_CYCLES) begin
						settle_cnt = 0;
						void'(pending_q.pop_front());
					end else settle_cnt++;
				end else if (pending_q[0].gap > 0) begin
					pending_q[0].gap = pending_q[0].gap - 1;
				end else begin
					if (pending_q[0].kind == ST_ITEM) begin
						nstart = 1'b1;
						in_item <= pending_q[0].item;
					end else begin
						nvalid = 1'b1;
						cfg_index <= pending_q[0].idx;
						cfg_data <= pending_q[0].data;
					end
					void'(pending_q.pop_front());
				end
			end
			start <= nstart;
			cfg_valid <= nvalid;
		end
	end

	// monitor and predictor, sampled on the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_acc <= 1'b0;
			cfg_acc <= 1'b0;
			stall_cnt <= 0;
		end else begin
			out_item_t exp_r;
			item_acc <= start && !busy;
			cfg_acc <= cfg_valid && cfg_ready;
			if (start && !busy) src_pixel_q.push_back(src_pixel_for(in_item));
			if (cfg_valid && cfg_ready && cfg_index < 4) size_regs[cfg_index[1:0]] = cfg_data;
			if (done) begin
				if (src_pixel_q.size() == 0) begin
					$error("unexpected result item %h", result);
					errors++;
				end else begin
					exp_r = src_pixel_q.pop_front();
					if (result.src_x !== exp_r.src_x) begin
						$error("src_x expected %0d actual %0d", exp_r.src_x, result.src_x);
						errors++;
					end
					if (result.src_y !== exp_r.src_y) begin
						$error("src_y expected %0d actual %0d", exp_r.src_y, result.src_y);
						errors++;
					end
					if (result.src_addr !== exp_r.src_addr) begin
						$error("src_addr expected %0d actual %0d", exp_r.src_addr,
							result.src_addr);
						errors++;
					end
					if (result.outside !== exp_r.outside) begin
						$error("outside expected %0d actual %0d", exp_r.outside,
							result.outside);
						errors++;
					end
				end
			end
			if ((start && !busy) || (cfg_valid && cfg_ready) || done) stall_cnt <= 0;
			else if (stall_cnt >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		int dw, dh, n, gmax;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		in_item = '0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		settle_cnt = 0;
		foreach (size_regs[i]) size_regs[i] = 1;

		// directed: reset sizes, then width fit, height fit, degenerate axes, clamps
		add_item(0, 0, 0);
		add_item(4095, 4095, 0);
		add_item(1, 0, 0);
		add_sizes(640, 480, 320, 320);
		add_item(0, 0, 0);
		add_item(319, 319, 0);
		add_item(0, 79, 0);
		add_item(160, 80, 0);
		add_item(320, 0, 0);
		add_sizes(100, 400, 300, 200);
		add_item(0, 0, 0);
		add_item(124, 100, 0);
		add_item(175, 199, 0);
		add_item(299, 199, 0);
		add_sizes(4096, 1, 1, 4096);
		add_item(0, 4095, 0);
		add_sizes(1, 4096, 4096, 1);
		add_item(4095, 0, 0);
		add_item(2048, 1, 0);
		add_sizes(0, 8191, 4097, 0);
		add_item(0, 0, 0);
		add_item(4095, 0, 0);
		add_drain();
		add_cfg(IDX_W'($urandom_range(4, 255)), 7);
		add_item(100, 0, 0);

		// random phases; some run back to back, others with random gaps
		for (int p = 0; p < 20; p++) begin
			add_sizes(rand_dim(), rand_dim(), rand_dim(), rand_dim());
			dw = int'(clamp_dim(pending_q[$-1].data));
			dh = int'(clamp_dim(pending_q[$].data));
			if ($urandom_range(0, 3) == 0) add_cfg(IDX_W'($urandom_range(4, 255)), $urandom);
			gmax = ($urandom_range(0, 2) == 0) ? 0 : 13;
			n = $urandom_range(50, 90);
			for (int k = 0; k < n; k++) begin
				add_item(rand_coord(dw), rand_coord(dh), $urandom_range(0, gmax));
				if ($urandom_range(0, 60) == 0) add_drain();
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (pending_q.size() == 0 && !start && !cfg_valid && src_pixel_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (src_pixel_q.size() != 0) errors++;
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule

// File: filelist.f
design/fapr_pkg.sv
design/fapr_setup.sv
design/fit_and_pad_resize_source_address.sv
design/fapr_checker.sv
tb/tb.sv
